// File: hdl/co2fc_pkg.sv
// Shared types and constants for the CO2 frame checker and level indicator.
// No dependencies; imported by every module of the block.
package co2fc_pkg;

	localparam int FRAME_LEN = 9;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [IDX_W-1:0] IDX_IDLE = IDX_W'(FRAME_LEN);
	localparam logic [IDX_W-1:0] POS_HIGH = 4'd2;
	localparam logic [IDX_W-1:0] POS_LOW  = 4'd3;
	localparam logic [IDX_W-1:0] POS_SUM  = 4'd8;

	localparam logic [2:0] EV_REQUEST = 3'd0;
	localparam logic [2:0] EV_BYTE    = 3'd1;
	localparam logic [2:0] EV_TICK    = 3'd2;
	localparam logic [2:0] EV_BUTTON  = 3'd3;
	localparam logic [2:0] EV_DISP_ON = 3'd4;
	localparam logic [2:0] EV_DISP_OFF = 3'd5;

	localparam logic [1:0] ST_NONE        = 2'd0;
	localparam logic [1:0] ST_VALID       = 2'd1;
	localparam logic [1:0] ST_CHECKSUM    = 2'd2;
	localparam logic [1:0] ST_IMPLAUSIBLE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WARN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLAUS_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAUS_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;

	localparam logic [15:0] WARN_RST     = 16'd1000;
	localparam logic [15:0] ALARM_RST    = 16'd2000;
	localparam logic [15:0] PLAUS_MIN_RST = 16'd200;
	localparam logic [15:0] PLAUS_MAX_RST = 16'd10000;
	localparam logic [15:0] DEBOUNCE_RST = 16'd100;
	localparam logic [15:0] SINCE_MAX    = 16'hFFFF;

	typedef struct packed {
		logic        display_enabled;
		logic        lamp_red;
		logic        lamp_yellow;
		logic        lamp_green;
		logic [1:0]  frame_status;
		logic [15:0] ppm_value;
	} result_t;

endpackage

// File: hdl/co2_frame_checker_level_indicator.sv
// Top level of the CO2 frame checker and level indicator.
// Depends on co2fc_pkg and co2fc_core; adds the output register and skid stage.
//
// Usage:
//   Slave stream: one event per transfer. s_tuser carries the event kind
//   (request, sensor byte, ms tick, button, display on, display off) and
//   s_tdata the received sensor byte.
//   Master stream: exactly one result per event: current reading, frame
//   status, the three level lamps and the display flag.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write
//   thresholds, plausible bounds and debounce time; cfg_ready is always high.
// Output: the result of an event is registered in the output register, or in the
//   skid register while the master side stalls. Throughput: one event per cycle
//   while the master side drains, set by the state update in the core on each transfer.
// Reset: frame idle until a request, reading zero, display on, registers at
//   their defaults, both output stages empty.
// Stall: with m_tready low one more event is taken into the skid stage, then
//   s_tready drops until the master side drains.
module co2_frame_checker_level_indicator
	import co2fc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	input  logic [2:0]           s_tuser,   // [2:0] req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [15:0] ppm_value, [16] lamp_green,
	                                        // [17] lamp_yellow, [18] lamp_red,
	                                        // [19] display_enabled, [23:20] zero
	output logic [1:0]           m_tuser,   // [1:0] frame_status
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	result_t res, out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    push, pop;

	assign s_tready  = ~skid_valid_q;
	assign cfg_ready = 1'b1;
	assign push      = s_tvalid & s_tready;
	assign pop       = out_valid_q & m_tready;

	co2fc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (push),
		.req_type  (s_tuser),
		.rx_byte   (s_tdata),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (out_valid_q)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (push && (pop || !out_valid_q)) begin
			out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.display_enabled, out_q.lamp_red,
	                   out_q.lamp_yellow, out_q.lamp_green, out_q.ppm_value};
	assign m_tuser  = out_q.frame_status;

endmodule

// File: hdl/co2fc_core.sv
// Frame collection, checksum test, debounce and lamp logic with the register file.
// Depends on co2fc_pkg; state advances on each transfer taken by the top level.
module co2fc_core
	import co2fc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [2:0]           req_type,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output result_t              res
);

	logic [15:0] warn_q, alarm_q, pmin_q, pmax_q, debounce_q;
	logic [IDX_W-1:0] byte_index_q, byte_index_d;
	logic [7:0]  sum_q, sum_d, high_q, high_d, low_q, low_d;
	logic [15:0] reading_q, reading_d, since_q, since_d;
	logic        show_q, show_d;
	logic [1:0]  status;
	logic [7:0]  expect_sum;
	logic [15:0] value;

	assign expect_sum = 8'(~sum_q + 8'd1);
	assign value      = {high_q, low_q};

	always_comb begin
		byte_index_d = byte_index_q;
		sum_d        = sum_q;
		high_d       = high_q;
		low_d        = low_q;
		reading_d    = reading_q;
		show_d       = show_q;
		since_d      = since_q;
		status       = ST_NONE;
		unique case (req_type)
			EV_REQUEST: begin
				byte_index_d = '0;
				sum_d        = '0;
			end
			EV_BYTE: begin
				if (byte_index_q < IDX_IDLE) begin
					if (byte_index_q >= 4'd1 && byte_index_q <= 4'd7)
						sum_d = 8'(sum_q + rx_byte);
					if (byte_index_q == POS_HIGH)
						high_d = rx_byte;
					if (byte_index_q == POS_LOW)
						low_d = rx_byte;
					if (byte_index_q == POS_SUM) begin
						if (rx_byte != expect_sum) begin
							status = ST_CHECKSUM;
						end else if (value < pmin_q || value > pmax_q) begin
							reading_d = '0;
							status    = ST_IMPLAUSIBLE;
						end else begin
							reading_d = value;
							status    = ST_VALID;
						end
					end
					byte_index_d = IDX_W'(byte_index_q + 4'd1);
				end
			end
			EV_TICK: begin
				if (since_q != SINCE_MAX)
					since_d = 16'(since_q + 16'd1);
			end
			EV_BUTTON: begin
				if (since_q >= debounce_q) begin
					show_d  = ~show_q;
					since_d = '0;
				end
			end
			EV_DISP_ON:  show_d = 1'b1;
			EV_DISP_OFF: show_d = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		res                 = '0;
		res.ppm_value       = reading_d;
		res.frame_status    = status;
		res.display_enabled = show_d;
		if (show_d && reading_d != 16'd0) begin
			priority if (reading_d < warn_q)
				res.lamp_green = 1'b1;
			else if (reading_d < alarm_q)
				res.lamp_yellow = 1'b1;
			else
				res.lamp_red = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= IDX_IDLE;
			sum_q        <= '0;
			high_q       <= '0;
			low_q        <= '0;
			reading_q    <= '0;
			show_q       <= 1'b1;
			since_q      <= '0;
		end else if (take) begin
			byte_index_q <= byte_index_d;
			sum_q        <= sum_d;
			high_q       <= high_d;
			low_q        <= low_d;
			reading_q    <= reading_d;
			show_q       <= show_d;
			since_q      <= since_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q     <= WARN_RST;
			alarm_q    <= ALARM_RST;
			pmin_q     <= PLAUS_MIN_RST;
			pmax_q     <= PLAUS_MAX_RST;
			debounce_q <= DEBOUNCE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_WARN:      warn_q     <= cfg_data;
				REG_ALARM:     alarm_q    <= cfg_data;
				REG_PLAUS_MIN: pmin_q     <= cfg_data;
				REG_PLAUS_MAX: pmax_q     <= cfg_data;
				REG_DEBOUNCE:  debounce_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/co2fc_checker.sv
// Port-level assertions for the CO2 frame checker and level indicator.
// Depends on co2fc_pkg; bound to the top level at the end of this file.
module co2fc_checker
	import co2fc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	a_lamp_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[18:16]))
		else $error("more than one lamp lit");

	a_lamp_display: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[18:16] != 3'b000) |-> m_tdata[19] && (m_tdata[15:0] != 16'd0))
		else $error("lamp lit without display or reading");

	a_implausible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_IMPLAUSIBLE) |-> m_tdata[15:0] == 16'd0)
		else $error("implausible frame left a nonzero reading");

	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind co2_frame_checker_level_indicator co2fc_checker u_co2fc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/tb_co2_frame_checker_level_indicator.sv
`timescale 1ns / 100ps
// Self-checking testbench for co2_frame_checker_level_indicator: queued event driver,
// result monitor and a predictor of frame, reading, lamp and display state.
// Depends on co2fc_pkg and the block's RTL only.
module tb_co2_frame_checker_level_indicator;
	import co2fc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int IDLE_PCT    = 35;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
	} sensor_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic [2:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WARN;
	logic [15:0]          cfg_data = '0;

	sensor_event_t event_q[$];
	result_t       reading_q[$];
	sensor_event_t drv_ev;
	logic          s_took = 1'b0;
	logic          cfg_took = 1'b0;
	logic          no_idle = 1'b0;
	int            queued_total = 0;
	int            accepted_total = 0;
	int            errors = 0;
	int            cycles = 0;

	logic [15:0] cur_warn = WARN_RST;
	logic [15:0] cur_alarm = ALARM_RST;
	logic [15:0] cur_min = PLAUS_MIN_RST;
	logic [15:0] cur_max = PLAUS_MAX_RST;
	logic [15:0] cur_debounce = DEBOUNCE_RST;
	logic [3:0]  frame_pos = IDX_IDLE;
	logic [7:0]  frame_sum = '0;
	logic [7:0]  ppm_hi = '0;
	logic [7:0]  ppm_lo = '0;
	logic [15:0] ppm_reading = '0;
	logic        show = 1'b1;
	logic [15:0] ms_since_press = '0;

	co2_frame_checker_level_indicator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #2 clk = ~clk;

	function automatic result_t advance_checker(logic [2:0] kind, logic [7:0] b);
		result_t    res;
		logic [1:0] status;
		logic [15:0] v;
		status = ST_NONE;
		case (kind)
			EV_REQUEST: begin
				frame_pos = '0;
				frame_sum = '0;
			end
			EV_BYTE: begin
				if (frame_pos < IDX_IDLE) begin
					if (frame_pos >= 4'd1 && frame_pos <= 4'd7)
						frame_sum = frame_sum + b;
					if (frame_pos == POS_HIGH)
						ppm_hi = b;
					if (frame_pos == POS_LOW)
						ppm_lo = b;
					if (frame_pos == POS_SUM) begin
						v = {ppm_hi, ppm_lo};
						if (b != 8'(9'h100 - frame_sum)) begin
							status = ST_CHECKSUM;
						end else if (v < cur_min || v > cur_max) begin
							ppm_reading = '0;
							status = ST_IMPLAUSIBLE;
						end else begin
							ppm_reading = v;
							status = ST_VALID;
						end
					end
					frame_pos = frame_pos + 4'd1;
				end
			end
			EV_TICK: begin
				if (ms_since_press != SINCE_MAX)
					ms_since_press = ms_since_press + 16'd1;
			end
			EV_BUTTON: begin
				if (ms_since_press >= cur_debounce) begin
					show = ~show;
					ms_since_press = '0;
				end
			end
			EV_DISP_ON: show = 1'b1;
			EV_DISP_OFF: show = 1'b0;
			default: ;
		endcase
		res = '0;
		res.ppm_value = ppm_reading;
		res.frame_status = status;
		res.display_enabled = show;
		if (show && ppm_reading != 0) begin
			if (ppm_reading < cur_warn)
				res.lamp_green = 1'b1;
			else if (ppm_reading < cur_alarm)
				res.lamp_yellow = 1'b1;
			else
				res.lamp_red = 1'b1;
		end
		return res;
	endfunction

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		s_took <= s_tvalid && s_tready;
		cfg_took <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WARN: cur_warn = cfg_data;
					REG_ALARM: cur_alarm = cfg_data;
					REG_PLAUS_MIN: cur_min = cfg_data;
					REG_PLAUS_MAX: cur_max = cfg_data;
					REG_DEBOUNCE: cur_debounce = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				reading_q.push_back(advance_checker(s_tuser, s_tdata));
				accepted_total++;
			end
			if (m_tvalid && m_tready) begin
				if (reading_q.size() == 0) begin
					$error("result transfer with no result pending");
					errors++;
				end else begin
					exp_r = reading_q.pop_front();
					check_field("ppm_value", exp_r.ppm_value, m_tdata[15:0]);
					check_field("lamp_green", exp_r.lamp_green, m_tdata[16]);
					check_field("lamp_yellow", exp_r.lamp_yellow, m_tdata[17]);
					check_field("lamp_red", exp_r.lamp_red, m_tdata[18]);
					check_field("display_enabled", exp_r.display_enabled, m_tdata[19]);
					check_field("pad", 0, m_tdata[23:20]);
					check_field("frame_status", exp_r.frame_status, m_tuser);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_took) begin
			if (event_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				drv_ev = event_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_ev.kind;
				s_tdata <= drv_ev.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
	end

	task automatic add_event(logic [2:0] kind, logic [7:0] data);
		sensor_event_t ev;
		ev.kind = kind;
		ev.data = data;
		event_q.push_back(ev);
		queued_total++;
	endtask

	// request, then the first n bytes of a frame carrying ppm
	task automatic add_frame(logic [15:0] ppm, int n, bit good_sum);
		logic [7:0] fb[9];
		logic [7:0] sum;
		for (int i = 0; i < 9; i++)
			fb[i] = 8'($urandom);
		fb[2] = ppm[15:8];
		fb[3] = ppm[7:0];
		sum = '0;
		for (int i = 1; i <= 7; i++)
			sum = sum + fb[i];
		fb[8] = 8'(9'h100 - sum);
		if (!good_sum)
			fb[8] = fb[8] ^ 8'($urandom_range(255, 1));
		add_event(EV_REQUEST, 8'($urandom));
		for (int i = 0; i < n; i++)
			add_event(EV_BYTE, fb[i]);
	endtask

	function automatic logic [15:0] pick_ppm();
		case ($urandom_range(11))
			0: return cur_min - 16'd1;
			1: return cur_min;
			2: return cur_max;
			3: return cur_max + 16'd1;
			4: return cur_warn - 16'd1;
			5: return cur_warn;
			6: return cur_alarm - 16'd1;
			7: return cur_alarm;
			8: return 16'($urandom);
			9: return '0;
			default: begin
				if (cur_min <= cur_max)
					return 16'($urandom_range(cur_max, cur_min));
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic random_traffic(int n);
		int start;
		int r;
		start = queued_total;
		while (queued_total - start < n) begin
			r = $urandom_range(99);
			if (r < 50) begin
				add_frame(pick_ppm(), 9, $urandom_range(99) < 85);
			end else if (r < 58) begin
				add_frame(pick_ppm(), $urandom_range(8), 1'b1);
			end else if (r < 62) begin
				add_frame(pick_ppm(), 9, 1'b1);
				repeat ($urandom_range(3, 1))
					add_event(EV_BYTE, 8'($urandom));
			end else if (r < 76) begin
				repeat ($urandom_range(40, 1))
					add_event(EV_TICK, 8'($urandom));
			end else if (r < 84) begin
				add_event(EV_BUTTON, 8'($urandom));
			end else if (r < 89) begin
				add_event(EV_DISP_ON, 8'($urandom));
			end else if (r < 93) begin
				add_event(EV_DISP_OFF, 8'($urandom));
			end else if (r < 96) begin
				add_event(3'($urandom_range(7, 6)), 8'($urandom));
			end else begin
				add_event(EV_BYTE, 8'($urandom));
			end
		end
	endtask

	task automatic settle();
		while (accepted_total != queued_total || reading_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_took);
	endtask

	task automatic load_settings(logic [15:0] warn, logic [15:0] alarm, logic [15:0] pmin,
			logic [15:0] pmax, logic [15:0] dbnc);
		cfg_valid <= 1'b1;
		put_reg(REG_WARN, warn);
		put_reg(REG_ALARM, alarm);
		put_reg(REG_PLAUS_MIN, pmin);
		put_reg(REG_PLAUS_MAX, pmax);
		put_reg(REG_DEBOUNCE, dbnc);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// press before the debounce window has elapsed, idle bytes, unused codes
		add_event(EV_BUTTON, 8'hFF);
		add_event(EV_BYTE, 8'h00);
		add_event(3'd7, 8'hFF);
		add_event(3'd6, 8'h00);
		// restart mid-frame, then a full good frame
		add_event(EV_REQUEST, 8'h00);
		add_event(EV_BYTE, 8'hFF);
		add_event(EV_BYTE, 8'h00);
		add_frame(16'd400, 9, 1'b1);
		add_event(EV_BYTE, 8'hAA);
		add_event(EV_DISP_OFF, 8'h00);
		add_event(EV_DISP_ON, 8'hFF);
		add_event(EV_TICK, 8'h5A);
		random_traffic(350);
		settle();

		load_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		random_traffic(350);
		settle();

		// crossed thresholds; run the press timer past the window with no idling
		no_idle <= 1'b1;
		load_settings(16'd3000, 16'd1500, 16'd0, 16'hFFFF, 16'd50);
		add_frame(16'd2500, 9, 1'b1);
		repeat (60) add_event(EV_TICK, 8'($urandom));
		add_event(EV_BUTTON, 8'($urandom));
		add_event(EV_BUTTON, 8'($urandom));
		random_traffic(350);
		settle();
		no_idle <= 1'b0;

		load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(1000)),
			16'($urandom_range(65535, 5000)), 16'($urandom_range(30)));
		random_traffic(350);
		settle();

		// crossed plausibility bounds
		load_settings(16'hFFFF, 16'hFFFF, 16'd5000, 16'd100, 16'd1);
		random_traffic(350);
		settle();

		if (reading_q.size() != 0) begin
			$error("%0d results never arrived", reading_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
